>>> src/sle_pkg.sv
package sle_pkg;

    localparam int SLE_QUEUE_DEPTH = 2;

    localparam logic [7:0] CH_QUOTE   = 8'h22;
    localparam logic [7:0] CH_BSLASH  = 8'h5C;
    localparam logic [7:0] CH_DOLLAR  = 8'h24;
    localparam logic [7:0] CH_AT      = 8'h40;
    localparam logic [7:0] CH_HASH    = 8'h23;
    localparam logic [7:0] CH_LBRACE  = 8'h7B;
    localparam logic [7:0] CH_UNDER   = 8'h5F;
    localparam logic [7:0] CH_X       = 8'h78;
    localparam logic [7:0] BYTE_LF    = 8'h0A;
    localparam logic [7:0] BYTE_TAB   = 8'h09;
    localparam logic [7:0] BYTE_CR    = 8'h0D;
    localparam logic [7:0] BYTE_VT    = 8'h0B;
    localparam logic [7:0] BYTE_FF    = 8'h0C;
    localparam logic [7:0] BYTE_ESC   = 8'h1B;
    localparam logic [7:0] BYTE_DEL   = 8'h7F;
    localparam logic [7:0] CTRL_LIMIT = 8'h20;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       first_of_string;
        logic       last_of_string;
        logic       empty_string;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_char;
        logic       run_last;
        logic       literal_end;
    } t_out_item;

    typedef enum logic [1:0] {
        ESC_PLAIN,
        ESC_NAMED,
        ESC_HEX
    } t_esc_cls;

    typedef enum logic [1:0] {
        SEG_HEAD,
        SEG_TAIL,
        SEG_CLOSE
    } t_seg;

    typedef struct packed {
        t_esc_cls   cls;
        logic [7:0] ch;
    } t_esc;

    typedef struct packed {
        logic       a_valid;
        t_esc       a;
        logic       b_valid;
        t_esc       b;
        logic       c_valid;
    } t_job;

    typedef struct packed {
        logic valid;
        t_job job;
    } t_job_slot;

    function automatic logic is_ident_start(input logic [7:0] c);
        return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A) || (c == CH_UNDER);
    endfunction

    function automatic logic [7:0] hex_digit(input logic [3:0] d);
        return (d < 4'd10) ? (8'h30 + {4'h0, d}) : (8'h37 + {4'h0, d});
    endfunction

    function automatic t_esc classify(input logic [7:0] c, input logic [7:0] nxt);
        t_esc e;
        e.cls = ESC_NAMED;
        e.ch  = c;
        case (c)
            BYTE_LF:   e.ch = 8'h6E;
            BYTE_TAB:  e.ch = 8'h74;
            BYTE_CR:   e.ch = 8'h72;
            BYTE_VT:   e.ch = 8'h76;
            BYTE_FF:   e.ch = 8'h66;
            BYTE_ESC:  e.ch = 8'h65;
            CH_BSLASH: e.ch = CH_BSLASH;
            CH_QUOTE:  e.ch = CH_QUOTE;
            CH_DOLLAR: begin
                if (!is_ident_start(nxt)) begin
                    e.cls = ESC_PLAIN;
                end
            end
            CH_LBRACE: begin
                if (!(nxt == CH_DOLLAR || nxt == CH_AT || nxt == CH_HASH)) begin
                    e.cls = ESC_PLAIN;
                end
            end
            default: begin
                e.cls = (c < CTRL_LIMIT || c == BYTE_DEL) ? ESC_HEX : ESC_PLAIN;
            end
        endcase
        return e;
    endfunction

endpackage

>>> src/sle_front.sv
module sle_front
    import sle_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in,
    input  logic      i_q_full,
    output t_job_slot o_push
);

    logic [7:0] r_held_byte;
    logic       r_held_valid;
    logic [7:0] n_held_byte;
    logic       n_held_valid;
    logic       accept;
    t_job       job;

    assign o_in_stall = i_q_full;
    assign accept     = i_in_valid && !i_q_full;

    always_comb begin
        job          = '0;
        n_held_byte  = r_held_byte;
        n_held_valid = r_held_valid;
        if (i_in.empty_string) begin
            job.a_valid  = 1'b1;
            job.a        = '{cls: ESC_PLAIN, ch: CH_QUOTE};
            job.c_valid  = 1'b1;
            n_held_byte  = '0;
            n_held_valid = 1'b0;
        end else begin
            if (i_in.first_of_string) begin
                job.a_valid = 1'b1;
                job.a       = '{cls: ESC_PLAIN, ch: CH_QUOTE};
            end else if (r_held_valid) begin
                job.a_valid = 1'b1;
                job.a       = classify(r_held_byte, i_in.data_byte);
            end
            if (i_in.last_of_string) begin
                job.b_valid  = 1'b1;
                job.b        = classify(i_in.data_byte, 8'h00);
                job.c_valid  = 1'b1;
                n_held_byte  = '0;
                n_held_valid = 1'b0;
            end else begin
                n_held_byte  = i_in.data_byte;
                n_held_valid = 1'b1;
            end
        end
    end

    always_comb begin
        o_push.job   = job;
        o_push.valid = accept && (job.a_valid || job.b_valid || job.c_valid);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held_valid <= 1'b0;
            r_held_byte  <= '0;
        end else if (accept) begin
            r_held_valid <= n_held_valid;
            r_held_byte  <= n_held_byte;
        end
    end

endmodule

>>> src/sle_queue.sv
module sle_queue
    import sle_pkg::*;
#(
    parameter int DEPTH = SLE_QUEUE_DEPTH
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_job_slot i_push,
    output logic      o_full,
    output t_job_slot o_head,
    input  logic      i_pop
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_job             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             do_push;
    logic             do_pop;

    assign o_full     = (r_count == CNT_W'(DEPTH));
    assign do_push    = i_push.valid && !o_full;
    assign do_pop     = i_pop && (r_count != '0);
    assign o_head.valid = (r_count != '0);
    assign o_head.job   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_push.job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("queue count exceeds depth");

    a_push_slot_taken: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (do_push && !do_pop) |=> (r_count == $past(r_count) + 1'b1))
        else $error("queue push lost");

endmodule

>>> src/sle_back.sv
module sle_back
    import sle_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_job_slot i_head,
    output logic      o_pop,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out
);

    t_seg       r_seg;
    logic [1:0] r_idx;
    t_seg       n_seg;
    logic [1:0] n_idx;
    logic       r_out_valid;
    t_out_item  r_out;
    t_out_item  n_out;
    logic       advance;
    logic       emit;
    logic [2:0] seg_v;
    t_seg       eff_seg;
    t_esc       cur;
    logic       is_close;
    logic [1:0] last_idx;
    logic       seg_end;
    logic       more;

    assign advance = !r_out_valid || !i_out_stall;
    assign emit    = advance && i_head.valid;
    assign seg_v   = {i_head.job.c_valid, i_head.job.b_valid, i_head.job.a_valid};

    always_comb begin
        if (r_seg == SEG_HEAD && seg_v[0]) begin
            eff_seg = SEG_HEAD;
        end else if (r_seg != SEG_CLOSE && seg_v[1]) begin
            eff_seg = SEG_TAIL;
        end else begin
            eff_seg = SEG_CLOSE;
        end
        is_close = 1'b0;
        case (eff_seg)
            SEG_HEAD: begin
                cur  = i_head.job.a;
                more = seg_v[1] || seg_v[2];
            end
            SEG_TAIL: begin
                cur  = i_head.job.b;
                more = seg_v[2];
            end
            default: begin
                cur      = '{cls: ESC_PLAIN, ch: CH_QUOTE};
                more     = 1'b0;
                is_close = 1'b1;
            end
        endcase
        case (cur.cls)
            ESC_NAMED: last_idx = 2'd1;
            ESC_HEX:   last_idx = 2'd3;
            default:   last_idx = 2'd0;
        endcase
        seg_end = (r_idx == last_idx);
    end

    always_comb begin
        n_out.run_last    = seg_end && !more;
        n_out.literal_end = is_close;
        case (cur.cls)
            ESC_NAMED: n_out.out_char = (r_idx == 2'd0) ? CH_BSLASH : cur.ch;
            ESC_HEX: begin
                case (r_idx)
                    2'd0:    n_out.out_char = CH_BSLASH;
                    2'd1:    n_out.out_char = CH_X;
                    2'd2:    n_out.out_char = hex_digit(cur.ch[7:4]);
                    default: n_out.out_char = hex_digit(cur.ch[3:0]);
                endcase
            end
            default: n_out.out_char = cur.ch;
        endcase
    end

    always_comb begin
        n_seg = r_seg;
        n_idx = r_idx;
        if (emit) begin
            if (!seg_end) begin
                n_seg = eff_seg;
                n_idx = r_idx + 1'b1;
            end else if (more) begin
                n_seg = (eff_seg == SEG_HEAD) ? SEG_TAIL : SEG_CLOSE;
                n_idx = 2'd0;
            end else begin
                n_seg = SEG_HEAD;
                n_idx = 2'd0;
            end
        end
    end

    assign o_pop       = emit && seg_end && !more;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seg       <= SEG_HEAD;
            r_idx       <= 2'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_seg <= n_seg;
            r_idx <= n_idx;
            if (advance) begin
                r_out_valid <= i_head.valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out <= n_out;
        end
    end

    a_end_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.literal_end) |-> (r_out.run_last && r_out.out_char == CH_QUOTE))
        else $error("closing quote not marked as last of its item");

    a_pop_resets_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> (r_seg == SEG_HEAD && r_idx == 2'd0))
        else $error("position not cleared after job done");

endmodule

>>> src/string_literal_escaper.sv
// The first character of an accepted item goes through the queue entry written at
// the accepting edge, then through the output register.
// Throughput: one item per cycle while each item yields at most one character and
// the output is not stalled; an item yielding more characters holds the back end
// until its last one is out, and the input stalls once the QUEUE_DEPTH-entry
// queue fills. Synchronous active-low reset clears held byte, queue, output valid.
module string_literal_escaper
    import sle_pkg::*;
#(
    parameter int QUEUE_DEPTH = SLE_QUEUE_DEPTH
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out
);

    t_job_slot push;
    t_job_slot head;
    logic      q_full;
    logic      pop;

    sle_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in       (i_in),
        .i_q_full   (q_full),
        .o_push     (push)
    );

    sle_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_full  (q_full),
        .o_head  (head),
        .i_pop   (pop)
    );

    sle_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (head),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out)
    );

endmodule

>>> tb/tb.sv
module tb
    import sle_pkg::*;
();

    typedef struct packed {
        t_in_item   item;
        logic [1:0] phase;
        logic       drain;
    } t_send;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_in_valid = 1'b0;
    logic      o_in_stall;
    t_in_item  i_in = '0;
    logic      o_out_valid;
    logic      i_out_stall = 1'b0;
    t_out_item o_out;

    t_send      send_queue[$];
    t_out_item  expected_chars[$];
    t_out_item  step_chars[$];
    logic [7:0] pend_byte = 8'h00;
    logic       pend_ok = 1'b0;
    logic       took_item = 1'b0;
    logic [1:0] cur_phase = 2'd0;
    logic [1:0] fill_phase = 2'd0;
    logic       fill_drain = 1'b0;
    int         err_count = 0;

    string_literal_escaper i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out)
    );

    always begin
        i_clk = 1'b1;
        #4;
        i_clk = 1'b0;
        #4;
    end

    function automatic int sender_idle_pct(input logic [1:0] ph);
        return (ph == 2'd0) ? 21 : (ph == 2'd1) ? 51 : 0;
    endfunction

    function automatic int receiver_idle_pct(input logic [1:0] ph);
        return (ph == 2'd0) ? 51 : (ph == 2'd1) ? 21 : 0;
    endfunction

    function automatic void emit(input logic [7:0] ch, input logic closing);
        t_out_item o;
        o.out_char    = ch;
        o.run_last    = 1'b0;
        o.literal_end = closing;
        step_chars.push_back(o);
    endfunction

    function automatic logic ident_lead(input logic [7:0] c);
        logic [7:0] low;
        low = c | 8'h20;
        return (low >= "a" && low <= "z") || c == CH_UNDER;
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] d);
        return (d > 4'd9) ? (8'h41 + {4'h0, d} - 8'd10) : (8'h30 + {4'h0, d});
    endfunction

    function automatic void escape_byte(input logic [7:0] c, input logic [7:0] nxt);
        logic [7:0] named;
        named = 8'h00;
        case (c)
            BYTE_LF:   named = "n";
            BYTE_TAB:  named = "t";
            BYTE_CR:   named = "r";
            BYTE_VT:   named = "v";
            BYTE_FF:   named = "f";
            BYTE_ESC:  named = "e";
            CH_BSLASH: named = CH_BSLASH;
            CH_QUOTE:  named = CH_QUOTE;
            CH_DOLLAR: begin
                if (ident_lead(nxt)) named = CH_DOLLAR;
            end
            CH_LBRACE: begin
                if (nxt == CH_DOLLAR || nxt == CH_AT || nxt == CH_HASH) named = CH_LBRACE;
            end
            default: ;
        endcase
        if (named != 8'h00) begin
            emit(CH_BSLASH, 1'b0);
            emit(named, 1'b0);
        end else if (c < CTRL_LIMIT || c == BYTE_DEL) begin
            emit(CH_BSLASH, 1'b0);
            emit(CH_X, 1'b0);
            emit(hex_char(c[7:4]), 1'b0);
            emit(hex_char(c[3:0]), 1'b0);
        end else begin
            emit(c, 1'b0);
        end
    endfunction

    function automatic void encode_item(input t_in_item it);
        t_out_item o;
        step_chars.delete();
        if (it.empty_string) begin
            pend_ok   = 1'b0;
            pend_byte = 8'h00;
            emit(CH_QUOTE, 1'b0);
            emit(CH_QUOTE, 1'b1);
        end else begin
            if (it.first_of_string) begin
                pend_ok = 1'b0;
                emit(CH_QUOTE, 1'b0);
            end else if (pend_ok) begin
                escape_byte(pend_byte, it.data_byte);
            end
            if (it.last_of_string) begin
                escape_byte(it.data_byte, 8'h00);
                emit(CH_QUOTE, 1'b1);
                pend_ok   = 1'b0;
                pend_byte = 8'h00;
            end else begin
                pend_byte = it.data_byte;
                pend_ok   = 1'b1;
            end
        end
        for (int i = 0; i < step_chars.size(); i++) begin
            o = step_chars[i];
            o.run_last = (i == step_chars.size() - 1);
            expected_chars.push_back(o);
        end
    endfunction

    task automatic queue_item(input logic [7:0] data, input logic first, input logic last,
                              input logic empty);
        t_send s;
        s.item.data_byte       = data;
        s.item.first_of_string = first;
        s.item.last_of_string  = last;
        s.item.empty_string    = empty;
        s.phase                = fill_phase;
        s.drain                = fill_drain;
        fill_drain             = 1'b0;
        send_queue.push_back(s);
    endtask

    function automatic logic [7:0] pick_char();
        int r;
        r = $urandom_range(0, 9);
        if (r < 3) return 8'($urandom);
        if (r == 3) return 8'($urandom_range(8'h61, 8'h7A));
        if (r < 6) return 8'($urandom_range(8'h20, 8'h7E));
        case ($urandom_range(0, 16))
            0:  return BYTE_LF;
            1:  return BYTE_TAB;
            2:  return BYTE_CR;
            3:  return BYTE_VT;
            4:  return BYTE_FF;
            5:  return BYTE_ESC;
            6:  return CH_BSLASH;
            7:  return CH_QUOTE;
            8:  return CH_DOLLAR;
            9:  return CH_LBRACE;
            10: return CH_AT;
            11: return CH_HASH;
            12: return CH_UNDER;
            13: return BYTE_DEL;
            14: return 8'h00;
            15: return 8'h1F;
            default: return 8'h20;
        endcase
    endfunction

    // accept side: predict on every accepted item
    always @(posedge i_clk) begin
        took_item <= i_rst_n && i_in_valid && !o_in_stall;
        if (i_rst_n && i_in_valid && !o_in_stall) encode_item(i_in);
    end

    always @(negedge i_clk) begin : drive_proc
        t_send nxt;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || took_item) begin
            if (send_queue.size() == 0
                    || (send_queue[0].drain && expected_chars.size() != 0)
                    || $urandom_range(0, 99) < sender_idle_pct(cur_phase)) begin
                i_in_valid <= 1'b0;
            end else begin
                nxt = send_queue.pop_front();
                i_in       <= nxt.item;
                i_in_valid <= 1'b1;
                cur_phase  <= nxt.phase;
            end
        end
    end

    always @(negedge i_clk) begin
        i_out_stall <= i_rst_n && ($urandom_range(0, 99) < receiver_idle_pct(cur_phase));
    end

    always @(posedge i_clk) begin : check_proc
        t_out_item want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_chars.size() == 0) begin
                $error("unexpected item: out_char %h", o_out.out_char);
                err_count++;
            end else begin
                want = expected_chars.pop_front();
                if (o_out.out_char !== want.out_char) begin
                    $error("out_char: expected %h, got %h", want.out_char, o_out.out_char);
                    err_count++;
                end
                if (o_out.run_last !== want.run_last) begin
                    $error("run_last: expected %b, got %b", want.run_last, o_out.run_last);
                    err_count++;
                end
                if (o_out.literal_end !== want.literal_end) begin
                    $error("literal_end: expected %b, got %b", want.literal_end,
                           o_out.literal_end);
                    err_count++;
                end
            end
        end
    end

    initial begin
        int sent;
        int len;
        // continuation with nothing held, then a first byte over a held one
        queue_item("A", 1'b0, 1'b0, 1'b0);
        queue_item(BYTE_LF, 1'b1, 1'b0, 1'b0);
        queue_item(BYTE_TAB, 1'b0, 1'b0, 1'b0);
        queue_item(BYTE_CR, 1'b0, 1'b0, 1'b0);
        queue_item(BYTE_VT, 1'b0, 1'b0, 1'b0);
        queue_item(BYTE_FF, 1'b0, 1'b0, 1'b0);
        queue_item(BYTE_ESC, 1'b0, 1'b0, 1'b0);
        queue_item(CH_BSLASH, 1'b0, 1'b0, 1'b0);
        queue_item(CH_QUOTE, 1'b0, 1'b0, 1'b0);
        queue_item(8'h00, 1'b0, 1'b0, 1'b0);
        queue_item(BYTE_DEL, 1'b0, 1'b0, 1'b0);
        queue_item(CH_DOLLAR, 1'b0, 1'b0, 1'b0);
        queue_item("Z", 1'b0, 1'b0, 1'b0);
        queue_item(CH_DOLLAR, 1'b0, 1'b0, 1'b0);
        queue_item(CH_UNDER, 1'b0, 1'b0, 1'b0);
        queue_item(CH_DOLLAR, 1'b0, 1'b0, 1'b0);
        queue_item("9", 1'b0, 1'b0, 1'b0);
        // empty string over a held byte, other fields set
        queue_item(8'hFF, 1'b1, 1'b1, 1'b1);
        queue_item(CH_LBRACE, 1'b1, 1'b0, 1'b0);
        queue_item(CH_AT, 1'b0, 1'b0, 1'b0);
        queue_item(CH_LBRACE, 1'b0, 1'b0, 1'b0);
        queue_item(CH_HASH, 1'b0, 1'b0, 1'b0);
        queue_item(CH_LBRACE, 1'b0, 1'b0, 1'b0);
        queue_item(CH_DOLLAR, 1'b0, 1'b0, 1'b0);
        queue_item(CH_LBRACE, 1'b0, 1'b0, 1'b0);
        queue_item(8'hFF, 1'b0, 1'b1, 1'b0);
        queue_item(CH_DOLLAR, 1'b1, 1'b1, 1'b0);

        sent = 0;
        fill_drain = 1'b1;
        while (sent < 133) begin
            if (sent >= 90 && fill_phase != 2'd2) begin
                fill_phase = 2'd2;
                fill_drain = 1'b1;
            end else if (sent >= 45 && fill_phase == 2'd0) begin
                fill_phase = 2'd1;
                fill_drain = 1'b1;
            end
            if ($urandom_range(0, 99) < 85) begin
                len = ($urandom_range(0, 9) == 0) ? 12 : $urandom_range(0, 6);
                if (len == 0) begin
                    queue_item(8'($urandom), 1'($urandom), 1'($urandom), 1'b1);
                    sent++;
                end
                for (int i = 0; i < len; i++) begin
                    queue_item(pick_char(), i == 0, i == len - 1, 1'b0);
                    sent++;
                end
            end else begin
                queue_item(8'($urandom), 1'($urandom), 1'($urandom),
                           $urandom_range(0, 7) == 0);
                sent++;
            end
        end

        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        @(posedge i_clk);
        while (send_queue.size() != 0 || i_in_valid || expected_chars.size() != 0)
            @(posedge i_clk);
        repeat (16) @(posedge i_clk);
        if (expected_chars.size() != 0)
            $error("%0d expected items never came", expected_chars.size());
        if (err_count == 0 && expected_chars.size() == 0) begin
            $display("tb: done, clean");
        end else begin
            $display("tb: done, errors");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("tb: done, errors");
        $finish;
    end

endmodule
